// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for concurrent assertions clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic form: explicit clock and reset
`define ASSERT_ON(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// house form: clock and reset of the enclosing module
`define ASSERT_CLK(label, prop, msg) `ASSERT_ON(label, clock, reset, prop, msg)

`endif

// ----- sv/dpfl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpfl_pkg
// Widths, limits and controller/datapath handshake types for the lister.
// ----------------------------------------------------------------------------
package dpfl_pkg;

   localparam int VALUE_BITS   = 16;
   localparam int REST_BITS    = VALUE_BITS - 1;
   localparam int FACTOR_BITS  = 15;
   localparam int MAX_RESULTS  = 6;
   localparam int COUNT_BITS   = $clog2(MAX_RESULTS + 1);
   localparam int DIV_CNT_BITS = $clog2(REST_BITS + 1);
   localparam int SQ_BITS      = 2 * REST_BITS;

   typedef struct packed {
      logic load;       // new transaction: load value, reset trial divisor
      logic inc_d;      // move on to next candidate
      logic store_d;    // candidate is a factor: keep it, take quotient
      logic store_t;    // leftover cofactor is a factor: keep it
      logic load_quot;  // divide out once more
      logic div_start;  // launch divider on rest / d
   } dpfl_cmd_type;

   typedef struct packed {
      logic sq_le_rest; // d*d <= rest
      logic count_ok;   // fewer than MAX_RESULTS factors kept
      logic rest_gt1;   // rest > 1
      logic pend_valid; // a factor waits in the pending register
      logic div_done;   // divider finished this cycle
      logic rem_zero;   // remainder is zero
   } dpfl_status_type;

endpackage

// ----- sv/dpfl_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpfl_req_if
// Request channel: one signed value per transaction.
// ----------------------------------------------------------------------------
interface dpfl_req_if;
   import dpfl_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// ----- sv/dpfl_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpfl_rsp_if
// Response channel: one prime factor per transaction, last marks the end.
// ----------------------------------------------------------------------------
interface dpfl_rsp_if;
   import dpfl_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [FACTOR_BITS-1:0] factor;
   logic                   has_factor;
   logic                   last;

   modport source (output valid, output factor, output has_factor, output last, input ready);
   modport sink   (input valid, input factor, input has_factor, input last, output ready);
endinterface

// ----- sv/dpfl_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpfl_div
// Restoring divider, one quotient bit per cycle; done pulses when finished.
// ----------------------------------------------------------------------------
module dpfl_div import dpfl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [REST_BITS-1:0] dividend,
   input  logic [REST_BITS-1:0] divisor,
   output logic [REST_BITS-1:0] quotient,
   output logic [REST_BITS-1:0] remainder,
   output logic                 done
);

   logic [REST_BITS-1:0]    rem_ff, rem_in;
   logic [REST_BITS-1:0]    quo_ff, quo_in;
   logic [REST_BITS-1:0]    dvs_ff, dvs_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [REST_BITS:0]      shifted;
   logic [REST_BITS:0]      diff;

   assign shifted = {rem_ff, quo_ff[REST_BITS-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = DIV_CNT_BITS'(REST_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // negative trial difference: keep the shifted remainder
         rem_in = diff[REST_BITS] ? shifted[REST_BITS-1:0] : diff[REST_BITS-1:0];
         quo_in = {quo_ff[REST_BITS-2:0], ~diff[REST_BITS]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

// ----- sv/dpfl_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpfl_datapath
// Remaining cofactor, trial divisor, factor count, pending factor, divider.
// ----------------------------------------------------------------------------
module dpfl_datapath import dpfl_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  dpfl_cmd_type           cmd,
   input  logic [VALUE_BITS-1:0]  value,
   output dpfl_status_type        status,
   output logic [FACTOR_BITS-1:0] factor,
   output logic                   has_factor
);

   logic [REST_BITS-1:0]   rest_ff, rest_in;
   logic [REST_BITS-1:0]   d_ff, d_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [FACTOR_BITS-1:0] pend_factor_ff, pend_factor_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [REST_BITS-1:0]   quotient;
   logic [REST_BITS-1:0]   remainder;
   logic                   div_done;
   logic [SQ_BITS-1:0]     d_sq;

   dpfl_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (rest_ff),
      .divisor   (d_ff),
      .quotient  (quotient),
      .remainder (remainder),
      .done      (div_done)
   );

   assign d_sq = SQ_BITS'(d_ff) * SQ_BITS'(d_ff);

   always_comb begin
      rest_in        = rest_ff;
      d_in           = d_ff;
      count_in       = count_ff;
      pend_factor_in = pend_factor_ff;
      pend_valid_in  = pend_valid_ff;
      if (cmd.load) begin
         // negative values map to zero: nothing to list
         rest_in        = value[VALUE_BITS-1] ? '0 : value[REST_BITS-1:0];
         d_in           = REST_BITS'(2);
         count_in       = '0;
         pend_factor_in = '0;
         pend_valid_in  = 1'b0;
      end
      if (cmd.inc_d) begin
         d_in = d_ff + 1'b1;
      end
      if (cmd.store_d) begin
         pend_factor_in = FACTOR_BITS'(d_ff);
         pend_valid_in  = 1'b1;
         count_in       = count_ff + 1'b1;
         rest_in        = quotient;
      end
      if (cmd.store_t) begin
         pend_factor_in = FACTOR_BITS'(rest_ff);
         pend_valid_in  = 1'b1;
         count_in       = count_ff + 1'b1;
      end
      if (cmd.load_quot) begin
         rest_in = quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         count_ff      <= count_in;
      end
      rest_ff        <= rest_in;
      d_ff           <= d_in;
      pend_factor_ff <= pend_factor_in;
   end

   assign status.sq_le_rest = d_sq <= SQ_BITS'(rest_ff);
   assign status.count_ok   = count_ff < COUNT_BITS'(MAX_RESULTS);
   assign status.rest_gt1   = rest_ff > REST_BITS'(1);
   assign status.pend_valid = pend_valid_ff;
   assign status.div_done   = div_done;
   assign status.rem_zero   = remainder == '0;

   assign factor     = pend_factor_ff;
   assign has_factor = pend_valid_ff;

endmodule

// ----- sv/dpfl_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpfl_ctrl
// Sequencer: trial loop, divide-out loop, and response transactions.
// ----------------------------------------------------------------------------
module dpfl_ctrl import dpfl_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic            rsp_last,
   input  dpfl_status_type status,
   output dpfl_cmd_type    cmd
);

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_TEST      = 9'b000000010,
      S_DIV       = 9'b000000100,
      S_SEND_D    = 9'b000001000,
      S_OUT_START = 9'b000010000,
      S_OUT_WAIT  = 9'b000100000,
      S_TAIL      = 9'b001000000,
      S_SEND_T    = 9'b010000000,
      S_FLUSH     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            if (status.sq_le_rest && status.count_ok) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_TAIL;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               if (!status.rem_zero) begin
                  cmd.inc_d = 1'b1;
                  state_in  = S_TEST;
               end else if (status.pend_valid) begin
                  // previous factor goes out first, now known not to be last
                  state_in = S_SEND_D;
               end else begin
                  cmd.store_d = 1'b1;
                  state_in    = S_OUT_START;
               end
            end
         end
         S_SEND_D: begin
            if (rsp_ready) begin
               cmd.store_d = 1'b1;
               state_in    = S_OUT_START;
            end
         end
         S_OUT_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (status.div_done) begin
               if (status.rem_zero) begin
                  cmd.load_quot = 1'b1;
                  state_in      = S_OUT_START;
               end else begin
                  cmd.inc_d = 1'b1;
                  state_in  = S_TEST;
               end
            end
         end
         S_TAIL: begin
            if (status.rest_gt1 && status.count_ok) begin
               if (status.pend_valid) begin
                  state_in = S_SEND_T;
               end else begin
                  cmd.store_t = 1'b1;
                  state_in    = S_FLUSH;
               end
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_SEND_T: begin
            if (rsp_ready) begin
               cmd.store_t = 1'b1;
               state_in    = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = (state_ff == S_SEND_D) || (state_ff == S_SEND_T) ||
                      (state_ff == S_FLUSH);
   assign rsp_last  = state_ff == S_FLUSH;

endmodule

// ----- sv/distinct_prime_factor_lister.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distinct_prime_factor_lister
// Lists the distinct prime factors of a signed 16-bit value, ascending.
// ----------------------------------------------------------------------------
// One value is taken at a time; the next request is accepted only after the
// final response (last high) has been taken. Values below two, negative ones
// included, give a single response with has_factor low and factor zero.
// Trial division runs over candidates d while d*d stays within the remaining
// cofactor, each found factor being divided out completely; what remains
// above one is the largest factor. Each trial or divide-out step runs in the
// shared bit-serial divider, one quotient bit per cycle.
// A factor is held back until the next one is found, so last is always known.
`include "assert_macros.svh"

module distinct_prime_factor_lister import dpfl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   dpfl_req_if.sink          req_ch,
   dpfl_rsp_if.source        rsp_ch
);

   dpfl_cmd_type    cmd;
   dpfl_status_type status;

   dpfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_last  (rsp_ch.last),
      .status    (status),
      .cmd       (cmd)
   );

   dpfl_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .value      (req_ch.value),
      .status     (status),
      .factor     (rsp_ch.factor),
      .has_factor (rsp_ch.has_factor)
   );

   `ASSERT_CLK(a_empty_is_last, rsp_ch.valid && !rsp_ch.has_factor |-> rsp_ch.last, "empty answer without last")
   `ASSERT_CLK(a_one_at_a_time, !(req_ch.ready && rsp_ch.valid), "request taken while responding")
   `ASSERT_CLK(a_busy_after_req, req_ch.valid && req_ch.ready |=> !req_ch.ready, "ready right after request")
   `ASSERT_CLK(a_factor_ge2, rsp_ch.valid && rsp_ch.has_factor |-> rsp_ch.factor > FACTOR_BITS'(1), "factor below two")

endmodule
